@@ rtl/topk_sorted_score_insert_core_assert.svh @@
// ----------------------------------------------------------------------------
// Top-k score table assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TOPK_SORTED_SCORE_INSERT_CORE_ASSERT_SVH
`define TOPK_SORTED_SCORE_INSERT_CORE_ASSERT_SVH

// Same-cycle implication.
`define TKINS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("topk table: same-cycle check failed");

// Next-cycle implication.
`define TKINS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("topk table: next-cycle check failed");

`endif

@@ rtl/tkins_pkg.sv @@
// ----------------------------------------------------------------------------
// Top-k score table package
// Field widths, mode codes and stream payload layouts.
// ----------------------------------------------------------------------------
package tkins_pkg;

  localparam int SCORE_W    = 32;
  localparam int NAME_TAG_W = 64;
  localparam int INDEX_W    = 4;
  localparam int RANK_W     = 4;
  localparam int COUNT_W    = 5;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 176;

  typedef logic signed [SCORE_W-1:0] score_t;

  typedef enum logic {
    MODE_SUBMIT = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

  // Request payload, lowest field in the lowest bits.
  typedef struct packed {
    logic [3:0]            pad;
    logic [INDEX_W-1:0]    read_index;
    logic [NAME_TAG_W-1:0] name_tag;
    score_t                score;
  } req_data_t;

  // Result payload, lowest field in the lowest bits.
  typedef struct packed {
    logic [4:0]            pad;
    logic [NAME_TAG_W-1:0] read_name;
    score_t                read_score;
    logic                  read_valid;
    score_t                lowest_score;
    score_t                highest_score;
    logic [COUNT_W-1:0]    entry_count;
    logic [RANK_W-1:0]     rank;
    logic                  accepted;
  } rsp_data_t;

endpackage

@@ rtl/tkins_cell.sv @@
// ----------------------------------------------------------------------------
// Top-k score table cell
// Holds one (score, name) entry; on insert keeps it, takes the new entry or
// takes the entry of the cell above.
// ----------------------------------------------------------------------------
module tkins_cell
  import tkins_pkg::*;
#(
  parameter int NAME_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ins_en_i,
  input  score_t            new_score_i,
  input  logic [NAME_W-1:0] new_name_i,
  input  logic              up_ge_i,
  input  logic              up_valid_i,
  input  score_t            up_score_i,
  input  logic [NAME_W-1:0] up_name_i,
  output logic              ge_o,
  output logic              valid_o,
  output score_t            score_o,
  output logic [NAME_W-1:0] name_o
);

  logic              valid_q, valid_d;
  score_t            score_q, score_d;
  logic [NAME_W-1:0] name_q, name_d;

  // Entry stays put when it is held and at least as high as the new one.
  assign ge_o = valid_q && (score_q >= new_score_i);

  always_comb begin
    valid_d = valid_q;
    score_d = score_q;
    name_d  = name_q;
    if (ins_en_i && !ge_o) begin
      if (up_ge_i) begin
        valid_d = 1'b1;
        score_d = new_score_i;
        name_d  = new_name_i;
      end else begin
        valid_d = up_valid_i;
        score_d = up_score_i;
        name_d  = up_name_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    name_q  <= name_d;
  end

  assign valid_o = valid_q;
  assign score_o = score_q;
  assign name_o  = name_q;

endmodule

@@ rtl/topk_sorted_score_insert_core.sv @@
// ----------------------------------------------------------------------------
// Flow: an accepted request is held in the pending registers, and the result
// register loads from them once the output is free. One request per cycle while
// the output does not stall; the cell row updates when a request is accepted.
// Reset: empties the table (cell valid bits and count clear), no pending work.
// ----------------------------------------------------------------------------
// Top-k score table
// Sorted row of cells holding the best MAX_ENTRIES scores, highest first.
// ----------------------------------------------------------------------------
module topk_sorted_score_insert_core
  import tkins_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int NAME_BYTES  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // score[31:0], name_tag[95:32], read_index[99:96], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode[0]
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // accepted[0], rank[4:1], entry_count[9:5], highest_score[41:10],
  // lowest_score[73:42], read_valid[74], read_score[106:75],
  // read_name[170:107], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  req_data_t req;
  logic      s_accept, ins_en;

  logic [MAX_ENTRIES-1:0] cell_valid, cell_ge, up_ge, up_valid, last_flag;
  score_t                 cell_score [MAX_ENTRIES];
  logic [NAME_W-1:0]      cell_name  [MAX_ENTRIES];
  score_t                 up_score   [MAX_ENTRIES];
  logic [NAME_W-1:0]      up_name    [MAX_ENTRIES];

  logic [CNT_W-1:0]  count_q, count_d;
  logic              pend_valid_q;
  logic              pend_read_q, pend_acc_q;
  logic [RANK_W-1:0] pend_rank_q;
  logic [INDEX_W-1:0] pend_idx_q;
  logic [WIDE_W-1:0] rank_wide;

  logic      load_out, m_valid_q;
  rsp_data_t rsp_d, rsp_q;

  assign req      = req_data_t'(s_axis_tdata);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  // Take the entry when positive and it beats the bottom cell (or a free one).
  assign ins_en   = s_accept && (mode_e'(s_axis_tuser[0]) == MODE_SUBMIT) &&
                    (req.score > 0) && !cell_ge[MAX_ENTRIES-1];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign up_ge[i]    = 1'b1;
      assign up_valid[i] = 1'b0;
      assign up_score[i] = '0;
      assign up_name[i]  = '0;
    end else begin : g_body
      assign up_ge[i]    = cell_ge[i-1];
      assign up_valid[i] = cell_valid[i-1];
      assign up_score[i] = cell_score[i-1];
      assign up_name[i]  = cell_name[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign last_flag[i] = cell_valid[i];
    end else begin : g_mid
      assign last_flag[i] = cell_valid[i] && !cell_valid[i+1];
    end

    tkins_cell #(
      .NAME_W (NAME_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ins_en_i    (ins_en),
      .new_score_i (req.score),
      .new_name_i  (req.name_tag[NAME_W-1:0]),
      .up_ge_i     (up_ge[i]),
      .up_valid_i  (up_valid[i]),
      .up_score_i  (up_score[i]),
      .up_name_i   (up_name[i]),
      .ge_o        (cell_ge[i]),
      .valid_o     (cell_valid[i]),
      .score_o     (cell_score[i]),
      .name_o      (cell_name[i])
    );
  end

  // Insert position is the boundary where cells stop holding scores at least as high.
  always_comb begin
    rank_wide = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (up_ge[i] && !cell_ge[i]) begin
        rank_wide = rank_wide | WIDE_W'(i);
      end
    end
  end

  assign count_d = count_q + CNT_W'(ins_en && !cell_valid[MAX_ENTRIES-1]);

  assign load_out      = pend_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_valid_q || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_accept) begin
        pend_valid_q <= 1'b1;
      end else if (load_out) begin
        pend_valid_q <= 1'b0;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      pend_read_q <= (mode_e'(s_axis_tuser[0]) == MODE_READ);
      pend_acc_q  <= ins_en;
      pend_rank_q <= ins_en ? rank_wide[RANK_W-1:0] : '0;
      pend_idx_q  <= req.read_index;
    end
    if (load_out) begin
      rsp_q <= rsp_d;
    end
  end

  // Cell row already reflects the pending request here.
  always_comb begin
    rsp_d               = '0;
    rsp_d.accepted      = pend_acc_q;
    rsp_d.rank          = pend_rank_q;
    rsp_d.entry_count   = COUNT_W'(count_q);
    rsp_d.highest_score = cell_valid[0] ? cell_score[0] : '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (last_flag[i]) begin
        rsp_d.lowest_score = rsp_d.lowest_score | cell_score[i];
      end
      if (pend_read_q && cell_valid[i] &&
          (WIDE_W'(pend_idx_q) == WIDE_W'(i))) begin
        rsp_d.read_valid = 1'b1;
        rsp_d.read_score = rsp_d.read_score | cell_score[i];
        rsp_d.read_name  = rsp_d.read_name | NAME_TAG_W'(cell_name[i]);
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(rsp_q);

  `include "topk_sorted_score_insert_core_assert.svh"

  // Held cells form an unbroken run from the top.
  `TKINS_ASSERT_IMPLY(a_valid_prefix, clk_i, rst_ni, 1'b1, (((cell_valid >> 1) & ~cell_valid) == '0))
  // The count tracks the number of held cells.
  `TKINS_ASSERT_IMPLY(a_count_match, clk_i, rst_ni, 1'b1, ($countones(cell_valid) == int'(count_q)))
  // An insert into a table with room grows it by one.
  `TKINS_ASSERT_NEXT(a_count_grow, clk_i, rst_ni, (ins_en && !cell_valid[MAX_ENTRIES-1]), (count_q == $past(count_q) + CNT_W'(1)))

endmodule
